>>> rtl/dxt_pkg.sv
// Shared types, constants and arithmetic helpers of the compressed texture block decoder.
package dxt_pkg;

	// Format codes held in the format register.
	localparam logic [2:0] FMT_DXT1 = 3'd0;
	localparam logic [2:0] FMT_DXT3 = 3'd1;
	localparam logic [2:0] FMT_DXT5 = 3'd2;
	localparam logic [2:0] FMT_ATI1 = 3'd3;
	localparam logic [2:0] FMT_ATI2 = 3'd4;

	localparam int unsigned TEXELS = 16;
	localparam logic [3:0] LAST_T = 4'(TEXELS - 1);

	// Reciprocals for exact division of the weighted sums (scaled by two to the fourteenth).
	localparam int unsigned RECIP_SHIFT = 14;
	localparam logic [12:0] RECIP3 = 13'd5462;
	localparam logic [12:0] RECIP5 = 13'd3277;
	localparam logic [12:0] RECIP7 = 13'd2341;

	// How a lane's weighted sum is turned into the final 8-bit value.
	typedef enum logic [2:0] {
		DIV_NONE,
		DIV_HALF,
		DIV_THIRD,
		DIV_FIFTH,
		DIV_SEVENTH
	} div_t;

	// Input block: two little-endian halves.
	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
	} dxt_blk_t;

	// One decoded texel.
	typedef struct packed {
		logic [1:0] texel_col;
		logic [1:0] texel_row;
		logic [7:0] chan_red;
		logic [7:0] chan_green;
		logic [7:0] chan_blue;
		logic [7:0] chan_alpha;
		logic       last_texel;
	} dxt_texel_t;

	// Texel issued by the sequencer.
	typedef struct packed {
		logic        valid;
		logic [2:0]  fmt;
		logic [3:0]  t;
		logic [63:0] lo;
		logic [63:0] hi;
	} issue_t;

	// Endpoints and index of one alpha-style ramp.
	typedef struct packed {
		logic [7:0] a0;
		logic [7:0] a1;
		logic [2:0] k;
	} ramp_t;

	// Fields pulled out of the block for one texel.
	typedef struct packed {
		logic       valid;
		logic [2:0] fmt;
		logic [3:0] t;
		logic       four;
		logic [1:0] ci;
		logic [2:0][7:0] p0;
		logic [2:0][7:0] p1;
		ramp_t      rlo;
		ramp_t      rhi;
		logic [3:0] nib;
	} s1_t;

	// Weighted sum awaiting its final division.
	typedef struct packed {
		logic [10:0] num;
		div_t        sel;
	} lane_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] fmt;
		logic [3:0] t;
		lane_t [2:0] col;
		lane_t      rlo;
		lane_t      rhi;
	} s2_t;

	// Weighted sum for one colour channel of the four-entry or three-entry palette.
	function automatic lane_t color_lane(input logic [7:0] p0, input logic [7:0] p1,
			input logic [1:0] ci, input logic four);
		lane_t l;
		l.num = 11'd0;
		l.sel = DIV_NONE;
		case (ci)
			2'd0: l.num = 11'(p0);
			2'd1: l.num = 11'(p1);
			2'd2: begin
				if (four) begin
					l.num = 11'({p0, 1'b0}) + 11'(p1) + 11'd1;
					l.sel = DIV_THIRD;
				end else begin
					l.num = 11'(p0) + 11'(p1) + 11'd1;
					l.sel = DIV_HALF;
				end
			end
			default: begin
				if (four) begin
					l.num = 11'(p0) + 11'({p1, 1'b0}) + 11'd1;
					l.sel = DIV_THIRD;
				end
			end
		endcase
		return l;
	endfunction

	// Weighted sum for one entry of an 8-step or 6-step ramp.
	function automatic lane_t ramp_lane(input ramp_t r);
		lane_t l;
		logic [3:0] w0;
		logic [3:0] w1;
		w1 = 4'(r.k) - 4'd1;
		w0 = (r.a0 > r.a1) ? 4'd8 - 4'(r.k) : 4'd6 - 4'(r.k);
		l.num = 11'(w0) * 11'(r.a0) + 11'(w1) * 11'(r.a1);
		l.sel = (r.a0 > r.a1) ? DIV_SEVENTH : DIV_FIFTH;
		if (r.k == 3'd0) begin
			l.num = 11'(r.a0);
			l.sel = DIV_NONE;
		end else if (r.k == 3'd1) begin
			l.num = 11'(r.a1);
			l.sel = DIV_NONE;
		end else if (!(r.a0 > r.a1) && r.k == 3'd6) begin
			l.num = 11'd0;
			l.sel = DIV_NONE;
		end else if (!(r.a0 > r.a1) && r.k == 3'd7) begin
			l.num = 11'd255;
			l.sel = DIV_NONE;
		end
		return l;
	endfunction

	// Division by a small constant through a reciprocal multiply.
	function automatic logic [7:0] resolve_lane(input lane_t l);
		logic [24:0] prod;
		logic [7:0]  res;
		prod = 25'd0;
		res = 8'd0;
		unique case (l.sel)
			DIV_NONE: res = l.num[7:0];
			DIV_HALF: res = l.num[8:1];
			DIV_THIRD: begin
				prod = 25'(l.num) * 25'(RECIP3);
				res = prod[RECIP_SHIFT +: 8];
			end
			DIV_FIFTH: begin
				prod = 25'(l.num) * 25'(RECIP5);
				res = prod[RECIP_SHIFT +: 8];
			end
			DIV_SEVENTH: begin
				prod = 25'(l.num) * 25'(RECIP7);
				res = prod[RECIP_SHIFT +: 8];
			end
			default: res = 8'd0;
		endcase
		return res;
	endfunction

endpackage

>>> rtl/dxt_seq.sv
// Block holding register, format register and texel sequencer issuing one texel a cycle.
module dxt_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dxt_pkg::dxt_blk_t blk,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_data,
	output dxt_pkg::issue_t   issue
);

	logic        active_q;
	logic [3:0]  cnt_q;
	logic [2:0]  fmt_cfg_q;
	logic [2:0]  fmt_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic        accept;

	// A new block may be taken while the last texel of the current one issues.
	assign busy = active_q && (cnt_q != dxt_pkg::LAST_T);
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;

	// Format register, written by a configuration transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_cfg_q <= dxt_pkg::FMT_DXT1;
		end else if (cfg_valid && cfg_ready) begin
			fmt_cfg_q <= cfg_data;
		end
	end

	// Texel counter and activity flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q <= 4'd0;
		end else if (accept) begin
			active_q <= 1'b1;
			cnt_q <= 4'd0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == dxt_pkg::LAST_T) begin
				active_q <= 1'b0;
			end
		end
	end

	// Block payload and the format it was taken with.
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= blk.block_low;
			hi_q <= blk.block_high;
			fmt_q <= fmt_cfg_q;
		end
	end

	// Texel handed to the first pipeline stage.
	always_comb begin
		issue.valid = active_q;
		issue.fmt = fmt_q;
		issue.t = cnt_q;
		issue.lo = lo_q;
		issue.hi = hi_q;
	end

	// A start transfer always restarts the count at the first texel.
	a_accept_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (active_q && cnt_q == 4'd0))
		else $error("sequencer did not restart on a start transfer");

	// Within a block the texel index advances by one every cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && cnt_q != dxt_pkg::LAST_T && !accept) |=>
		(active_q && cnt_q == $past(cnt_q) + 4'd1))
		else $error("texel index skipped or stalled");

endmodule

>>> rtl/dxt_extract.sv
// First stage: pulls endpoints, indices and mode flags for the current texel out of the block.
module dxt_extract (
	input  logic            clk,
	input  logic            arst_n,
	input  dxt_pkg::issue_t issue,
	output dxt_pkg::s1_t    st_s1
);

	logic [63:0] cblk;
	logic [15:0] c0;
	logic [15:0] c1;
	logic [31:0] csh;
	logic [5:0]  kshift;
	logic [47:0] lo_sh;
	logic [47:0] hi_sh;
	logic [63:0] nib_sh;
	dxt_pkg::s1_t nxt;

	// Field extraction for one texel.
	always_comb begin
		cblk = (issue.fmt == dxt_pkg::FMT_DXT1) ? issue.lo : issue.hi;
		c0 = cblk[15:0];
		c1 = cblk[31:16];
		csh = cblk[63:32] >> {issue.t, 1'b0};
		kshift = 6'({issue.t, 1'b0}) + 6'(issue.t);
		lo_sh = issue.lo[63:16] >> kshift;
		hi_sh = issue.hi[63:16] >> kshift;
		nib_sh = issue.lo >> {issue.t, 2'b00};

		nxt.valid = issue.valid;
		nxt.fmt = issue.fmt;
		nxt.t = issue.t;
		nxt.four = (c0 > c1) || (issue.fmt == dxt_pkg::FMT_DXT5);
		nxt.ci = csh[1:0];
		nxt.p0[0] = {c0[15:11], 3'b000};
		nxt.p0[1] = {c0[10:5], 2'b00};
		nxt.p0[2] = {c0[4:0], 3'b000};
		nxt.p1[0] = {c1[15:11], 3'b000};
		nxt.p1[1] = {c1[10:5], 2'b00};
		nxt.p1[2] = {c1[4:0], 3'b000};
		nxt.rlo.a0 = issue.lo[7:0];
		nxt.rlo.a1 = issue.lo[15:8];
		nxt.rlo.k = lo_sh[2:0];
		nxt.rhi.a0 = issue.hi[7:0];
		nxt.rhi.a1 = issue.hi[15:8];
		nxt.rhi.k = hi_sh[2:0];
		nxt.nib = nib_sh[3:0];
	end

	// Stage register, cleared on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else begin
			st_s1 <= nxt;
		end
	end

endmodule

>>> rtl/dxt_weight.sv
// Second stage: forms the weighted palette and ramp sums for the current texel.
module dxt_weight (
	input  logic         clk,
	input  logic         arst_n,
	input  dxt_pkg::s1_t st_s1,
	output dxt_pkg::s2_t st_s2
);

	dxt_pkg::s2_t nxt;

	// Colour lanes, the low ramp (or explicit DXT3 alpha) and the high ramp.
	always_comb begin
		nxt.valid = st_s1.valid;
		nxt.fmt = st_s1.fmt;
		nxt.t = st_s1.t;
		for (int i = 0; i < 3; i++) begin
			nxt.col[i] = dxt_pkg::color_lane(st_s1.p0[i], st_s1.p1[i], st_s1.ci, st_s1.four);
		end
		if (st_s1.fmt == dxt_pkg::FMT_DXT3) begin
			nxt.rlo.num = 11'({st_s1.nib, st_s1.nib});
			nxt.rlo.sel = dxt_pkg::DIV_NONE;
		end else begin
			nxt.rlo = dxt_pkg::ramp_lane(st_s1.rlo);
		end
		nxt.rhi = dxt_pkg::ramp_lane(st_s1.rhi);
	end

	// Stage register, cleared on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else begin
			st_s2 <= nxt;
		end
	end

endmodule

>>> rtl/dxt_resolve.sv
// Third stage: divides the sums by their constants and routes lanes to channels by format.
module dxt_resolve (
	input  logic                clk,
	input  logic                arst_n,
	input  dxt_pkg::s2_t        st_s2,
	output logic                texel_strobe,
	output dxt_pkg::dxt_texel_t texel
);

	logic [2:0][7:0] col;
	logic [7:0] rlo;
	logic [7:0] rhi;
	dxt_pkg::dxt_texel_t nxt;

	// Constant division of every lane, then the per-format channel map.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			col[i] = dxt_pkg::resolve_lane(st_s2.col[i]);
		end
		rlo = dxt_pkg::resolve_lane(st_s2.rlo);
		rhi = dxt_pkg::resolve_lane(st_s2.rhi);

		nxt.texel_col = st_s2.t[1:0];
		nxt.texel_row = st_s2.t[3:2];
		nxt.last_texel = (st_s2.t == dxt_pkg::LAST_T);
		nxt.chan_red = 8'd0;
		nxt.chan_green = 8'd0;
		nxt.chan_blue = 8'd0;
		nxt.chan_alpha = 8'd0;
		unique case (st_s2.fmt) inside
			dxt_pkg::FMT_DXT1: begin
				nxt.chan_red = col[0];
				nxt.chan_green = col[1];
				nxt.chan_blue = col[2];
			end
			dxt_pkg::FMT_DXT3, dxt_pkg::FMT_DXT5: begin
				nxt.chan_red = col[0];
				nxt.chan_green = col[1];
				nxt.chan_blue = col[2];
				nxt.chan_alpha = rlo;
			end
			dxt_pkg::FMT_ATI1: begin
				nxt.chan_red = rlo;
			end
			dxt_pkg::FMT_ATI2: begin
				nxt.chan_red = rhi;
				nxt.chan_green = rlo;
			end
			default: begin
				nxt.chan_red = 8'd0;
			end
		endcase
	end

	// Output register and its strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_strobe <= 1'b0;
		end else begin
			texel_strobe <= st_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		texel <= nxt;
	end

endmodule

>>> rtl/dxt_texture_block_decoder_unit.sv
// Top level of the compressed texture block decoder.
// Decodes one 16-byte DXT1, DXT3, DXT5, ATI1N or ATI2N block into its sixteen texels in
// row-major order, one texel per clock cycle on texel with texel_strobe high for that cycle;
// the receiver cannot stall and must take every texel in the cycle it appears. A block is
// taken at an edge where start is high and busy is low, and its sixteen texels share the single
// texel lane, so a new block can be taken back to back with no gap in the output; busy
// drops during the cycle in which the sixteenth texel of the current block issues. The first
// texel of a block passes from the sequencer, loaded at the edge of its start transfer, through
// the extraction and weighting stage registers and the output register to the ports. The format
// register is written through the cfg channel,
// which is always ready; it should be changed only while no block is in flight, and each block
// keeps the format that was set when it was taken.
module dxt_texture_block_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dxt_pkg::dxt_blk_t   blk,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_data,
	output logic                texel_strobe,
	output dxt_pkg::dxt_texel_t texel
);

	dxt_pkg::issue_t issue;
	dxt_pkg::s1_t    st_s1;
	dxt_pkg::s2_t    st_s2;

	// Sequencer issuing one texel per cycle.
	dxt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.blk       (blk),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.issue     (issue)
	);

	// Field extraction.
	dxt_extract u_extract (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.st_s1  (st_s1)
	);

	// Weighted sums.
	dxt_weight u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.st_s1  (st_s1),
		.st_s2  (st_s2)
	);

	// Division and channel routing.
	dxt_resolve u_resolve (
		.clk          (clk),
		.arst_n       (arst_n),
		.st_s2        (st_s2),
		.texel_strobe (texel_strobe),
		.texel        (texel)
	);

	// Every issued texel leaves the pipeline through the extraction, weighting and output registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> ##3 texel_strobe)
		else $error("issued texel did not reach the output");

	// Texels of one block leave without gaps.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(texel_strobe && !texel.last_texel) |=> texel_strobe)
		else $error("gap inside a block's texel run");

	// Consecutive texels of a block advance in row-major order.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(texel_strobe && !texel.last_texel) |=>
		({texel.texel_row, texel.texel_col} ==
		$past({texel.texel_row, texel.texel_col}) + 4'd1))
		else $error("texel coordinates out of order");

endmodule
